[design/bobdi_pkg.sv]
`default_nettype none

package bobdi_pkg;

  localparam int unsigned MAX_WIDTH  = 2048;
  localparam int unsigned MAX_HEIGHT = 4096;
  localparam int unsigned NUM_LINES  = 6;

  localparam int unsigned COL_W  = $clog2(MAX_WIDTH);
  localparam int unsigned ROW_W  = $clog2(MAX_HEIGHT);
  localparam int unsigned SLOT_W = $clog2(NUM_LINES);

  localparam int unsigned WIDTH_W  = 12;
  localparam int unsigned HEIGHT_W = 13;
  localparam int unsigned PADDR_W  = 4;
  localparam int unsigned PDATA_W  = 32;

  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_TFF    = 2'd2;

  typedef logic [NUM_LINES-1:0][7:0] col_word_t;

  typedef struct packed {
    logic [WIDTH_W-1:0]  width;
    logic [HEIGHT_W-1:0] height;
    logic                tff;
  } cfg_t;

  typedef struct packed {
    logic [7:0]        pixel;
    logic [ROW_W-1:0]  row;
    logic [COL_W-1:0]  col;
    logic [2:0]        rmin;
    logic [SLOT_W-1:0] slot;
    logic              par;
    logic [1:0]        jstart;
    logic              has_out;
    logic              last_row;
    logic              eop;
  } item_t;

  function automatic logic [7:0] line_pick(input col_word_t word, input logic [7:0] pix,
                                           input logic [SLOT_W-1:0] slot,
                                           input logic [2:0] off);
    logic [SLOT_W:0] tmp;
    logic [SLOT_W:0] idx;
    tmp = {1'b0, slot} + (SLOT_W+1)'(NUM_LINES) - {1'b0, off};
    idx = ({1'b0, slot} >= {1'b0, off}) ? ({1'b0, slot} - {1'b0, off}) : tmp;
    if (off == 3'd0) begin
      return pix;
    end
    return word[idx[SLOT_W-1:0]];
  endfunction

endpackage

`default_nettype wire

[design/bobdi_cfg.sv]
`default_nettype none

module bobdi_cfg (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bobdi_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bobdi_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bobdi_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready,
  output bobdi_pkg::cfg_t                     cfg_o
);

  bobdi_pkg::cfg_t cfg_q, cfg_d;
  logic            wr_en;
  logic [1:0]      idx;

  assign pready = 1'b1;
  assign idx    = paddr[3:2];
  assign wr_en  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_d = cfg_q;
    if (wr_en) begin
      case (idx)
        bobdi_pkg::REG_WIDTH:  cfg_d.width  = pwdata[bobdi_pkg::WIDTH_W-1:0];
        bobdi_pkg::REG_HEIGHT: cfg_d.height = pwdata[bobdi_pkg::HEIGHT_W-1:0];
        bobdi_pkg::REG_TFF:    cfg_d.tff    = pwdata[0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      bobdi_pkg::REG_WIDTH:
        prdata = {{(bobdi_pkg::PDATA_W-bobdi_pkg::WIDTH_W){1'b0}}, cfg_q.width};
      bobdi_pkg::REG_HEIGHT:
        prdata = {{(bobdi_pkg::PDATA_W-bobdi_pkg::HEIGHT_W){1'b0}}, cfg_q.height};
      bobdi_pkg::REG_TFF:
        prdata = {{(bobdi_pkg::PDATA_W-1){1'b0}}, cfg_q.tff};
      default:
        prdata = '0;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.width  <= bobdi_pkg::WIDTH_W'(2048);
      cfg_q.height <= bobdi_pkg::HEIGHT_W'(1080);
      cfg_q.tff    <= 1'b1;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

[design/bobdi_line_mem.sv]
`default_nettype none

module bobdi_line_mem (
  input  wire logic                           clk_i,
  input  wire logic                           en_i,
  input  wire logic [bobdi_pkg::COL_W-1:0]    addr_i,
  input  wire logic [bobdi_pkg::SLOT_W-1:0]   slot_i,
  input  wire logic [7:0]                     wdata_i,
  output bobdi_pkg::col_word_t                rdata_o
);

  bobdi_pkg::col_word_t line_mem [bobdi_pkg::MAX_WIDTH];
  bobdi_pkg::col_word_t rdata_q;

  // read returns the column before this beat's pixel lands in its lane
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      rdata_q                  <= line_mem[addr_i];
      line_mem[addr_i][slot_i] <= wdata_i;
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

[design/bobdi_expand.sv]
`default_nettype none

module bobdi_expand (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           load_i,
  input  wire bobdi_pkg::item_t               item_i,
  input  wire bobdi_pkg::col_word_t           word_i,
  output logic                                free_o,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [bobdi_pkg::ROW_W-1:0]    out_row_o,
  output logic      [bobdi_pkg::COL_W-1:0]    out_col_o,
  output logic      [7:0]                     out_value_o,
  output logic                                was_interpolated_o,
  output logic                                last_of_run_o,
  output logic                                end_of_plane_o
);

  bobdi_pkg::item_t item_q;
  logic             busy_q, busy_d;
  logic [1:0]       j_q, j_d;

  logic             out_valid_q;
  logic [bobdi_pkg::ROW_W-1:0] row_q;
  logic [bobdi_pkg::COL_W-1:0] col_q;
  logic [7:0]       val_q;
  logic             interp_q, lor_q, eop_q;

  logic        out_ready, emit, final_beat;
  logic [2:0]  b_off, c_off, b_raw, c_raw;
  logic [7:0]  a_v, b_v, c_v, d_v, cp_v, val;
  logic [8:0]  bc, ad;
  logic [12:0] nine;
  logic signed [13:0] acc;
  logic        interp, cubic, y_zero, y_last;

  assign out_ready  = !out_valid_q || !out_stall_i;
  assign final_beat = !item_q.last_row || (j_q == 2'd0);
  assign emit       = busy_q && item_q.has_out && out_ready;
  assign free_o     = !busy_q || !item_q.has_out || (out_ready && final_beat);

  assign b_raw = {1'b0, j_q} + 3'd1;
  assign c_raw = (j_q == 2'd0) ? 3'd0 : ({1'b0, j_q} - 3'd1);
  assign b_off = (b_raw > item_q.rmin) ? item_q.rmin : b_raw;
  assign c_off = (c_raw > item_q.rmin) ? item_q.rmin : c_raw;

  assign a_v  = bobdi_pkg::line_pick(word_i, item_q.pixel, item_q.slot, 3'd6);
  assign b_v  = bobdi_pkg::line_pick(word_i, item_q.pixel, item_q.slot, b_off);
  assign c_v  = bobdi_pkg::line_pick(word_i, item_q.pixel, item_q.slot, c_off);
  assign d_v  = item_q.pixel;
  assign cp_v = bobdi_pkg::line_pick(word_i, item_q.pixel, item_q.slot, {1'b0, j_q});

  assign bc   = {1'b0, b_v} + {1'b0, c_v};
  assign ad   = {1'b0, a_v} + {1'b0, d_v};
  assign nine = {1'b0, bc, 3'b000} + {4'b0000, bc};
  assign acc  = $signed({1'b0, nine}) + 14'sd8 - $signed({5'b00000, ad});

  assign interp = item_q.par ^ j_q[0];
  assign cubic  = (j_q == 2'd3) && (item_q.rmin == 3'd6);
  assign y_zero = (item_q.row == {{(bobdi_pkg::ROW_W-2){1'b0}}, j_q});
  assign y_last = item_q.last_row && (j_q == 2'd0);

  always_comb begin
    if (!interp) begin
      val = cp_v;
    end else if (cubic) begin
      if (acc[13]) begin
        val = 8'd0;
      end else if (acc[12]) begin
        val = 8'd255;
      end else begin
        val = acc[11:4];
      end
    end else if (y_zero) begin
      val = c_v;
    end else if (y_last) begin
      val = b_v;
    end else begin
      val = bc[8:1];
    end
  end

  always_comb begin
    busy_d = busy_q;
    j_d    = j_q;
    if (emit && !final_beat) begin
      j_d = j_q - 2'd1;
    end
    if (free_o) begin
      busy_d = load_i;
      if (load_i) begin
        j_d = item_i.jstart;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q      <= 1'b0;
      j_q         <= 2'd0;
      out_valid_q <= 1'b0;
    end else begin
      busy_q <= busy_d;
      j_q    <= j_d;
      if (out_ready) begin
        out_valid_q <= emit;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (free_o && load_i) begin
      item_q <= item_i;
    end
    if (emit) begin
      row_q    <= item_q.row - {{(bobdi_pkg::ROW_W-2){1'b0}}, j_q};
      col_q    <= item_q.col;
      val_q    <= val;
      interp_q <= interp;
      lor_q    <= final_beat;
      eop_q    <= item_q.eop && (j_q == 2'd0);
    end
  end

  assign out_valid_o        = out_valid_q;
  assign out_row_o          = row_q;
  assign out_col_o          = col_q;
  assign out_value_o        = val_q;
  assign was_interpolated_o = interp_q;
  assign last_of_run_o      = lor_q;
  assign end_of_plane_o     = eop_q;

endmodule

`default_nettype wire

[design/field_bob_cubic_deinterlacer_top.sv]
// channel   | direction | beat fields
// ----------+-----------+-------------------------------------------------------------
// in        | sink      | pixel_i, second_output_i
// out       | source    | out_row_o, out_col_o, out_value_o, was_interpolated_o,
//           |           | last_of_run_o, end_of_plane_o
// cfg (APB) | sink      | plane_width @0x0, plane_height @0x4, top_field_first @0x8
//
// One input beat per cycle while in_stall_o is low; expander and output are registered.
// The last source row yields up to four results per beat, one per cycle while
// out_stall_i is low, and in_stall_o high meanwhile; the output register sets that rate.
// A single 2048 x 48-bit column memory, read and written once per beat, holds six lines.
// Reset clears counters and valids and sets config defaults; memory is not cleared.
// out_stall_i backs up through the output register and expander into in_stall_o.
`default_nettype none

module field_bob_cubic_deinterlacer_top (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           in_valid_i,
  output logic                                in_stall_o,
  input  wire logic [7:0]                     pixel_i,
  input  wire logic                           second_output_i,
  output logic                                out_valid_o,
  input  wire logic                           out_stall_i,
  output logic      [bobdi_pkg::ROW_W-1:0]    out_row_o,
  output logic      [bobdi_pkg::COL_W-1:0]    out_col_o,
  output logic      [7:0]                     out_value_o,
  output logic                                was_interpolated_o,
  output logic                                last_of_run_o,
  output logic                                end_of_plane_o,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [bobdi_pkg::PADDR_W-1:0]  paddr,
  input  wire logic [bobdi_pkg::PDATA_W-1:0]  pwdata,
  output logic      [bobdi_pkg::PDATA_W-1:0]  prdata,
  output logic                                pready
);

  bobdi_pkg::cfg_t      cfg;
  bobdi_pkg::item_t     item;
  bobdi_pkg::col_word_t word;

  logic [bobdi_pkg::ROW_W-1:0]  row_q, row_d;
  logic [bobdi_pkg::COL_W-1:0]  col_q, col_d;
  logic [bobdi_pkg::SLOT_W-1:0] slot_q, slot_d;

  logic [bobdi_pkg::WIDTH_W-1:0]  w_eff;
  logic [bobdi_pkg::HEIGHT_W-1:0] h_eff;
  logic accept, free, col_wrap, last_row, kept_par;

  bobdi_cfg u_cfg (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg_o   (cfg)
  );

  assign in_stall_o = !free;
  assign accept     = in_valid_i && free;

  always_comb begin
    if (cfg.width == '0) begin
      w_eff = bobdi_pkg::WIDTH_W'(1);
    end else if (cfg.width > bobdi_pkg::WIDTH_W'(bobdi_pkg::MAX_WIDTH)) begin
      w_eff = bobdi_pkg::WIDTH_W'(bobdi_pkg::MAX_WIDTH);
    end else begin
      w_eff = cfg.width;
    end
    if (cfg.height == '0) begin
      h_eff = bobdi_pkg::HEIGHT_W'(1);
    end else if (cfg.height > bobdi_pkg::HEIGHT_W'(bobdi_pkg::MAX_HEIGHT)) begin
      h_eff = bobdi_pkg::HEIGHT_W'(bobdi_pkg::MAX_HEIGHT);
    end else begin
      h_eff = cfg.height;
    end
  end

  assign col_wrap = (bobdi_pkg::WIDTH_W'(col_q) + bobdi_pkg::WIDTH_W'(1)) >= w_eff;
  assign last_row = (bobdi_pkg::HEIGHT_W'(row_q) + bobdi_pkg::HEIGHT_W'(1)) >= h_eff;
  assign kept_par = (cfg.tff == second_output_i);

  always_comb begin
    item.pixel    = pixel_i;
    item.row      = row_q;
    item.col      = col_q;
    item.rmin     = (row_q >= bobdi_pkg::ROW_W'(6)) ? 3'd6 : row_q[2:0];
    item.slot     = slot_q;
    item.par      = row_q[0] ^ kept_par;
    item.has_out  = last_row || (row_q >= bobdi_pkg::ROW_W'(3));
    item.last_row = last_row;
    item.eop      = last_row && col_wrap;
    if (last_row && (row_q < bobdi_pkg::ROW_W'(3))) begin
      item.jstart = row_q[1:0];
    end else begin
      item.jstart = 2'd3;
    end
  end

  always_comb begin
    row_d  = row_q;
    col_d  = col_q;
    slot_d = slot_q;
    if (accept) begin
      if (col_wrap) begin
        col_d = '0;
        if (last_row) begin
          row_d  = '0;
          slot_d = '0;
        end else begin
          row_d  = row_q + bobdi_pkg::ROW_W'(1);
          slot_d = (slot_q == bobdi_pkg::SLOT_W'(bobdi_pkg::NUM_LINES - 1)) ? '0
                   : slot_q + bobdi_pkg::SLOT_W'(1);
        end
      end else begin
        col_d = col_q + bobdi_pkg::COL_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q  <= '0;
      col_q  <= '0;
      slot_q <= '0;
    end else begin
      row_q  <= row_d;
      col_q  <= col_d;
      slot_q <= slot_d;
    end
  end

  bobdi_line_mem u_mem (
    .clk_i   (clk_i),
    .en_i    (accept),
    .addr_i  (col_q),
    .slot_i  (slot_q),
    .wdata_i (pixel_i),
    .rdata_o (word)
  );

  bobdi_expand u_expand (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .load_i             (accept),
    .item_i             (item),
    .word_i             (word),
    .free_o             (free),
    .out_valid_o        (out_valid_o),
    .out_stall_i        (out_stall_i),
    .out_row_o          (out_row_o),
    .out_col_o          (out_col_o),
    .out_value_o        (out_value_o),
    .was_interpolated_o (was_interpolated_o),
    .last_of_run_o      (last_of_run_o),
    .end_of_plane_o     (end_of_plane_o)
  );

endmodule

`default_nettype wire

[design/bobdi_checker.sv]
`default_nettype none

module bobdi_checker (
  input wire logic                           clk_i,
  input wire logic                           rst_ni,
  input wire logic                           out_valid_o,
  input wire logic                           out_stall_i,
  input wire logic [bobdi_pkg::ROW_W-1:0]    out_row_o,
  input wire logic [bobdi_pkg::COL_W-1:0]    out_col_o,
  input wire logic [7:0]                     out_value_o,
  input wire logic                           was_interpolated_o,
  input wire logic                           last_of_run_o,
  input wire logic                           end_of_plane_o,
  input wire logic                           pready
);

  a_pready_high: assert property (@(posedge clk_i) disable iff (!rst_ni) pready)
    else $error("pready dropped");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_value_o)
      && $stable(out_row_o) && $stable(out_col_o) && $stable(was_interpolated_o))
    else $error("stalled output beat changed");

  a_eop_ends_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && end_of_plane_o |-> last_of_run_o)
    else $error("end of plane not on last beat of a run");

  a_run_next_row: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !last_of_run_o |=> out_valid_o
      && (out_row_o == $past(out_row_o) + bobdi_pkg::ROW_W'(1))
      && (out_col_o == $past(out_col_o)))
    else $error("run did not continue on the next row");

endmodule

bind field_bob_cubic_deinterlacer_top bobdi_checker u_bobdi_checker (.*);

`default_nettype wire

[test/field_bob_cubic_deinterlacer_top_test.sv]
`default_nettype none

module field_bob_cubic_deinterlacer_top_test;
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [bobdi_pkg::ROW_W-1:0] row;
    logic [bobdi_pkg::COL_W-1:0] col;
    logic [7:0]                  value;
    logic                        interp;
    logic                        last;
    logic                        eop;
  } out_px_t;

  class bob_scoreboard;
    logic [7:0] lines [bobdi_pkg::NUM_LINES][bobdi_pkg::MAX_WIDTH];
    int         width = 2048;
    int         height = 1080;
    bit         tff = 1'b1;
    int         row;
    int         col;
    int         accepted;
    int         errors;
    out_px_t    due [$];

    function void set_reg(logic [1:0] idx, logic [31:0] value);
      case (idx)
        bobdi_pkg::REG_WIDTH: width = int'(value & 32'hFFF);
        bobdi_pkg::REG_HEIGHT: height = int'(value & 32'h1FFF);
        bobdi_pkg::REG_TFF: tff = value[0];
        default: ;
      endcase
    endfunction

    function bit at_plane_start();
      return row == 0 && col == 0;
    endfunction

    function int tap(int q, int last, int cur, int x, logic [7:0] pix);
      if (q < 0) q = 0;
      if (q > last) q = last;
      if (q == cur) return int'(pix);
      return int'(lines[q % bobdi_pkg::NUM_LINES][x]);
    endfunction

    function int cubic(int a, int b, int c, int d);
      int v;
      v = 9 * (b + c) - (a + d) + 8;
      if (v < 0) return 0;
      v = v >>> 4;
      return (v > 255) ? 255 : v;
    endfunction

    function void note_pixel(logic [7:0] pix, logic sec);
      int      w, h, r, x, last, first, stop, y, v, kept;
      bit      last_row, interp;
      out_px_t px;
      w = (width == 0) ? 1 : (width > bobdi_pkg::MAX_WIDTH) ? bobdi_pkg::MAX_WIDTH : width;
      h = (height == 0) ? 1 : (height > bobdi_pkg::MAX_HEIGHT) ? bobdi_pkg::MAX_HEIGHT : height;
      r = row;
      x = col % bobdi_pkg::MAX_WIDTH;
      last_row = (r + 1 >= h);
      last = last_row ? r : h - 1;
      kept = (tff != sec) ? 0 : 1;
      if (last_row) begin
        first = (r >= 3) ? r - 3 : 0;
        stop = r;
      end else if (r >= 3) begin
        first = r - 3;
        stop = r - 3;
      end else begin
        first = 1;
        stop = 0;
      end
      for (y = first; y <= stop; y++) begin
        interp = ((y % 2) != kept);
        if (!interp) begin
          v = tap(y, last, r, x, pix);
        end else if (y >= 3 && y < last - 2) begin
          v = cubic(tap(y - 3, last, r, x, pix), tap(y - 1, last, r, x, pix),
                    tap(y + 1, last, r, x, pix), tap(y + 3, last, r, x, pix));
        end else if (y == 0) begin
          v = tap(1, last, r, x, pix);
        end else if (y == last) begin
          v = tap(y - 1, last, r, x, pix);
        end else begin
          v = (tap(y - 1, last, r, x, pix) + tap(y + 1, last, r, x, pix)) >> 1;
        end
        px.row = y[bobdi_pkg::ROW_W-1:0];
        px.col = x[bobdi_pkg::COL_W-1:0];
        px.value = v[7:0];
        px.interp = interp;
        px.last = (y == stop);
        px.eop = last_row && y == stop && col + 1 >= w;
        due.push_back(px);
      end
      lines[r % bobdi_pkg::NUM_LINES][x] = pix;
      accepted++;
      if (col + 1 >= w) begin
        col = 0;
        row = last_row ? 0 : r + 1;
      end else begin
        col++;
      end
    endfunction

    function void compare(string name, logic [11:0] want, logic [11:0] got);
      if (want !== got) begin
        errors++;
        $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
    endfunction

    function void check_pixel(logic [bobdi_pkg::ROW_W-1:0] r, logic [bobdi_pkg::COL_W-1:0] c,
                              logic [7:0] v, logic i, logic l, logic e);
      out_px_t want;
      if (due.size() == 0) begin
        errors++;
        $display("%0t: unexpected result, expected none, got row %0d col %0d value %0d",
                 $time, r, c, v);
        return;
      end
      want = due.pop_front();
      compare("out_row", 12'(want.row), 12'(r));
      compare("out_col", 12'(want.col), 12'(c));
      compare("out_value", 12'(want.value), 12'(v));
      compare("was_interpolated", 12'(want.interp), 12'(i));
      compare("last_of_run", 12'(want.last), 12'(l));
      compare("end_of_plane", 12'(want.eop), 12'(e));
    endfunction
  endclass

  logic                           clk_i = 1'b0;
  logic                           rst_ni = 1'b0;
  logic                           in_valid_i = 1'b0;
  logic                           in_stall_o;
  logic [7:0]                     pixel_i = 8'h00;
  logic                           second_output_i = 1'b0;
  logic                           out_valid_o;
  logic                           out_stall_i = 1'b0;
  logic [bobdi_pkg::ROW_W-1:0]    out_row_o;
  logic [bobdi_pkg::COL_W-1:0]    out_col_o;
  logic [7:0]                     out_value_o;
  logic                           was_interpolated_o;
  logic                           last_of_run_o;
  logic                           end_of_plane_o;
  logic                           psel = 1'b0;
  logic                           penable = 1'b0;
  logic                           pwrite = 1'b0;
  logic [bobdi_pkg::PADDR_W-1:0]  paddr = '0;
  logic [bobdi_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [bobdi_pkg::PDATA_W-1:0]  prdata;
  logic                           pready;

  bob_scoreboard sb = new();
  logic [7:0]    dir_pix [$];
  int            sec_mode;
  int            burst_left;
  int            stall_kind;
  int            stall_span;

  field_bob_cubic_deinterlacer_top u_top (.*);

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  initial begin
    #10ms;
    $display("[FAIL] regression broken");
    $finish;
  end

  always @(negedge clk_i) begin
    if (stall_span == 0) begin
      stall_kind = $urandom_range(0, 2);
      stall_span = $urandom_range(20, 80);
    end else begin
      stall_span = stall_span - 1;
    end
    case (stall_kind)
      0: out_stall_i <= 1'b0;
      1: out_stall_i <= ($urandom_range(0, 99) < 40);
      default: out_stall_i <= (stall_span % 3 == 0);
    endcase
  end

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o === 1'b1 && !out_stall_i) begin
      sb.check_pixel(out_row_o, out_col_o, out_value_o, was_interpolated_o,
                     last_of_run_o, end_of_plane_o);
    end
  end

  task automatic apb_write(input logic [1:0] idx, input logic [31:0] value);
    @(negedge clk_i);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= value;
    @(negedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.set_reg(idx, value);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
  endtask

  task automatic wait_for_quiet();
    while (sb.due.size() != 0) @(negedge clk_i);
    repeat (6) @(negedge clk_i);
  endtask

  task automatic set_plane(input int w, input int h, input int t);
    wait_for_quiet();
    apb_write(bobdi_pkg::REG_WIDTH, w);
    apb_write(bobdi_pkg::REG_HEIGHT, h);
    apb_write(bobdi_pkg::REG_TFF, t);
  endtask

  // stream n pixels, or up to the end of the current plane when to_end is set
  task automatic stream(input int n, input bit to_end);
    int         sent;
    int         gap;
    logic [7:0] pix;
    logic       sec;
    sent = 0;
    @(negedge clk_i);
    while (to_end ? (sent == 0 || !sb.at_plane_start()) : (sent < n)) begin
      if (burst_left <= 0) begin
        burst_left = ($urandom_range(0, 5) == 0) ? $urandom_range(20, 60) : $urandom_range(1, 12);
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 7);
        if (gap > 0) begin
          in_valid_i <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
      end
      if (dir_pix.size() != 0) begin
        pix = dir_pix.pop_front();
      end else if ($urandom_range(0, 4) == 0) begin
        pix = ($urandom_range(0, 1) == 1) ? 8'hFF : 8'h00;
      end else begin
        pix = 8'($urandom_range(0, 255));
      end
      if (sec_mode == 2) begin
        sec = 1'($urandom_range(0, 1));
      end else begin
        sec = sec_mode[0];
      end
      in_valid_i <= 1'b1;
      pixel_i <= pix;
      second_output_i <= sec;
      // hold the beat until it is taken
      do @(posedge clk_i); while (in_stall_o);
      sb.note_pixel(pix, sec);
      sent++;
      burst_left--;
      @(negedge clk_i);
    end
    in_valid_i <= 1'b0;
  endtask

  initial begin
    logic [7:0] ramp [8];
    int         start;
    int         w;
    int         h;
    int         k;
    ramp = '{8'hFF, 8'hFF, 8'h00, 8'h00, 8'h00, 8'h00, 8'hFF, 8'hFF};
    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    for (k = 0; k < 8; k++) begin
      dir_pix.push_back(ramp[k]);
      dir_pix.push_back(~ramp[k]);
    end
    sec_mode = 0;
    set_plane(2, 8, 1);
    stream(0, 1);

    dir_pix.push_back(8'hA5);
    sec_mode = 1;
    set_plane(0, 0, 0);
    stream(0, 1);

    dir_pix.push_back(8'h00);
    dir_pix.push_back(8'hFF);
    dir_pix.push_back(8'h11);
    dir_pix.push_back(8'hC8);
    set_plane(1, 4, 0);
    stream(0, 1);

    // drop the height below the current row mid-plane
    sec_mode = 2;
    set_plane(1, 8191, 1);
    stream(7, 0);
    wait_for_quiet();
    apb_write(bobdi_pkg::REG_HEIGHT, 4);
    stream(0, 1);

    start = sb.accepted;
    while (sb.accepted - start < 70) begin
      if ($urandom_range(0, 7) == 0) begin
        w = $urandom_range(7, 16);
        h = $urandom_range(4, 8);
      end else begin
        w = $urandom_range(1, 6);
        h = $urandom_range(4, 11);
      end
      sec_mode = $urandom_range(0, 2);
      set_plane(w, h, $urandom_range(0, 1));
      if ($urandom_range(0, 2) == 0) begin
        stream($urandom_range(1, w * h - 1), 0);
        wait_for_quiet();
        if ($urandom_range(0, 1) == 1) begin
          apb_write(bobdi_pkg::REG_HEIGHT, $urandom_range(4, 11));
        end else begin
          apb_write(bobdi_pkg::REG_TFF, $urandom_range(0, 1));
        end
      end
      stream(0, 1);
    end

    sec_mode = 2;
    set_plane(4095, 0, 0);
    stream(6, 0);

    wait_for_quiet();
    if (sb.errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

`default_nettype wire
